// ===== sv/tcce_pkg.sv =====
package tcce_pkg;

    // Fixed field widths of the item ports
    localparam int CELL_W    = 16;
    localparam int CODE_W    = 8;
    localparam int IDX_W     = 11;
    localparam int POS_W     = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // Operation codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Character codes
    localparam logic [CODE_W-1:0] CH_BS       = 8'd8;
    localparam logic [CODE_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CODE_W-1:0] CH_LF       = 8'd10;
    localparam logic [CODE_W-1:0] CH_FF       = 8'd12;
    localparam logic [CODE_W-1:0] CH_CR       = 8'd13;
    localparam logic [CODE_W-1:0] CH_SPACE    = 8'd32;
    localparam logic [CODE_W-1:0] CH_PRINT_HI = 8'd126;

    localparam logic [CELL_W-1:0] ATTR_RESET = 16'd512;

    typedef struct packed {
        logic              operation;
        logic [CODE_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } req_t;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_word;
        logic [POS_W-1:0]     cursor_position;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_column;
    } rsp_t;

endpackage

// ===== sv/tcce_frame_store.sv =====
module tcce_frame_store #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11,
    parameter int DW    = 16
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/text_console_char_engine_core.sv =====
// A printable or cursor moving item passes through the execute, place and done states
// before done strobes; a read, an ignored code or a backspace at column 0 goes from
// execute straight to done. Line feed or wrap on the last row and form feed add a frame
// sweep, one frame store cell copied or blanked per cycle.
// One item at a time: start is taken only when idle, also while done shows, and not
// while busy; the receiver cannot stall. Reset clears the cursor, attribute to 512, not the frame.
module text_console_char_engine_core #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tcce_pkg::req_t               request,
    output logic                         done,
    output tcce_pkg::rsp_t               result,
    input  logic                         cfg_write,
    input  logic [tcce_pkg::CELL_W-1:0]  cfg_data
);

    import tcce_pkg::*;

    // Geometry
    localparam int CELLS      = ROWS * COLUMNS;
    localparam int AW         = $clog2(CELLS);
    localparam int CNTW       = $clog2(CELLS + 1);
    localparam int SRCW       = $clog2(CELLS + COLUMNS);
    localparam int RW         = $clog2(ROWS);
    localparam int CW         = $clog2(COLUMNS);
    localparam int TW         = $clog2(TAB_WIDTH);
    localparam int IW         = (CNTW > IDX_W) ? CNTW : IDX_W;
    localparam int PW         = (AW > POS_W) ? AW : POS_W;
    localparam int ROW_XW     = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;
    localparam int COL_XW     = (CW > COL_OUT_W) ? CW : COL_OUT_W;
    localparam int LAST_COL   = COLUMNS - 1;
    localparam int LAST_ROW   = ROWS - 1;
    localparam int TAB_LIMIT  = COLUMNS - TAB_WIDTH;
    localparam int LAST_PHASE = (COLUMNS - 1) % TAB_WIDTH;
    localparam int MOVE_CELLS = CELLS - COLUMNS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_SWEEP = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg,   state_next;
    req_t              req_reg,     req_next;
    logic [RW-1:0]     row_reg,     row_next;
    logic [CW-1:0]     col_reg,     col_next;
    logic [TW-1:0]     phase_reg,   phase_next;
    logic [POS_W-1:0]  cursor_reg,  cursor_next;
    logic [CELL_W-1:0] attr_reg,    attr_next;
    logic [CNTW-1:0]   sweep_reg,   sweep_next;
    logic              clear_reg,   clear_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [AW-1:0]     wr_addr_reg, wr_addr_next;
    logic              wr_copy_reg, wr_copy_next;
    logic              done_reg,    done_next;
    rsp_t              result_reg,  result_next;

    // Frame store port signals
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [CELL_W-1:0] mem_q;

    // Helpers
    logic [IW-1:0]     idx_ext;
    logic              idx_in_range;
    logic [PW-1:0]     pos_wide;
    logic [AW-1:0]     cur_addr;
    logic [SRCW-1:0]   sweep_src;
    logic              sweep_issue;
    logic              sweep_copy;
    logic              col_last;
    logic              row_last;
    logic [CELL_W-1:0] blank_word;
    logic [ROW_XW-1:0] row_ext;
    logic [COL_XW-1:0] col_ext;

    assign idx_ext      = IW'(req_reg.cell_index);
    assign idx_in_range = idx_ext < IW'(CELLS);
    assign pos_wide     = PW'(row_reg) * PW'(COLUMNS) + PW'(col_reg);
    assign cur_addr     = pos_wide[AW-1:0];
    assign sweep_src    = SRCW'(sweep_reg) + SRCW'(COLUMNS);
    assign sweep_issue  = sweep_reg != CNTW'(CELLS);
    assign sweep_copy   = !clear_reg && (sweep_reg < CNTW'(MOVE_CELLS));
    assign col_last     = col_reg == CW'(LAST_COL);
    assign row_last     = row_reg == RW'(LAST_ROW);
    assign blank_word   = attr_reg | CELL_W'(CH_SPACE);
    assign row_ext      = ROW_XW'(row_reg);
    assign col_ext      = COL_XW'(col_reg);

    tcce_frame_store #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_frame (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        phase_next   = phase_reg;
        cursor_next  = cursor_reg;
        attr_next    = attr_reg;
        sweep_next   = sweep_reg;
        clear_next   = clear_reg;
        wr_pend_next = 1'b0;
        wr_addr_next = wr_addr_reg;
        wr_copy_next = wr_copy_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = attr_reg | CELL_W'(req_reg.char_code);
        mem_raddr = idx_ext[AW-1:0];

        if (cfg_write)
        begin
            attr_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = request;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                // Reads leave on the next step; the store read is already issued
                state_next = S_DONE;
                if (req_reg.operation == OP_CHAR)
                begin
                    case (req_reg.char_code) inside
                        [CH_SPACE:CH_PRINT_HI]:
                        begin
                            mem_we = 1'b1;
                            if (!col_last)
                            begin
                                col_next   = col_reg + CW'(1);
                                phase_next = (phase_reg == TW'(TAB_WIDTH - 1)) ?
                                             '0 : phase_reg + TW'(1);
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                col_next   = '0;
                                phase_next = '0;
                                if (!row_last)
                                begin
                                    row_next   = row_reg + RW'(1);
                                    state_next = S_PLACE;
                                end
                                else
                                begin
                                    sweep_next = '0;
                                    clear_next = 1'b0;
                                    state_next = S_SWEEP;
                                end
                            end
                        end
                        CH_LF:
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            if (!row_last)
                            begin
                                row_next   = row_reg + RW'(1);
                                state_next = S_PLACE;
                            end
                            else
                            begin
                                sweep_next = '0;
                                clear_next = 1'b0;
                                state_next = S_SWEEP;
                            end
                        end
                        CH_BS:
                        begin
                            // Hold the cursor at column zero
                            if (col_reg != '0)
                            begin
                                col_next   = col_reg - CW'(1);
                                phase_next = (phase_reg == '0) ?
                                             TW'(TAB_WIDTH - 1) : phase_reg - TW'(1);
                                state_next = S_PLACE;
                            end
                        end
                        CH_TAB:
                        begin
                            if (col_reg < CW'(TAB_LIMIT))
                            begin
                                col_next   = col_reg + CW'(TAB_WIDTH) - CW'(phase_reg);
                                phase_next = '0;
                            end
                            else
                            begin
                                col_next   = CW'(LAST_COL);
                                phase_next = TW'(LAST_PHASE);
                            end
                            state_next = S_PLACE;
                        end
                        CH_CR:
                        begin
                            col_next   = '0;
                            phase_next = '0;
                            state_next = S_PLACE;
                        end
                        CH_FF:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            phase_next = '0;
                            sweep_next = '0;
                            clear_next = 1'b1;
                            state_next = S_SWEEP;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SWEEP:
            begin
                // Issue a read one row below, or blank the cell; write it back in the next cycle
                if (sweep_copy)
                begin
                    mem_raddr = sweep_src[AW-1:0];
                end
                mem_we    = wr_pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = wr_copy_reg ? mem_q : blank_word;
                if (sweep_issue)
                begin
                    wr_pend_next = 1'b1;
                    wr_addr_next = sweep_reg[AW-1:0];
                    wr_copy_next = sweep_copy;
                    sweep_next   = sweep_reg + CNTW'(1);
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                cursor_next = pos_wide[POS_W-1:0];
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                result_next.cell_word       = ((req_reg.operation == OP_READ) && idx_in_range) ?
                                              mem_q : '0;
                result_next.cursor_position = cursor_reg;
                result_next.cursor_row      = row_ext[ROW_OUT_W-1:0];
                result_next.cursor_column   = col_ext[COL_OUT_W-1:0];
                done_next                   = 1'b1;
                state_next                  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            phase_reg   <= '0;
            cursor_reg  <= '0;
            attr_reg    <= ATTR_RESET;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            phase_reg   <= phase_next;
            cursor_reg  <= cursor_next;
            attr_reg    <= attr_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= done_next;
        end
    end

    // Payload and sweep bookkeeping
    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        sweep_reg   <= sweep_next;
        clear_reg   <= clear_next;
        wr_addr_reg <= wr_addr_next;
        wr_copy_reg <= wr_copy_next;
        result_reg  <= result_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/tcce_checker.sv =====
module tcce_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result shows only once the engine is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done strobe while busy");

    // An accepted item makes the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but engine not busy");

    // Each result is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A result follows work on an item
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding work");

endmodule

bind text_console_char_engine_core tcce_checker u_tcce_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
